FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the retention block; dra_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clock, but not while reset is high.
`define DRA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising edge of clock, during reset too.
`define DRA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/dra_pkg.sv
// ----------------------------------------------------------------------------
// dra_pkg
// Types and constants shared by the controller and datapath of the decayed
// retention block.
// ----------------------------------------------------------------------------
package dra_pkg;

   localparam int ELEM_W      = 16;
   localparam int DECAY_W     = 16;
   localparam int STATE_W     = 32;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd61440;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic row_wr;     // write one request into the row buffers
      logic upd_issue;  // issue one matrix update element
      logic out_issue;  // issue one product of an output column
      logic out_first;  // first product of the column
      logic out_last;   // last product of the column
      logic col_last;   // column is the final one of the row
      logic set_zero;   // matrix reads as zero from now on
      logic clr_zero;   // matrix holds real data from now on
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic upd_busy;   // update writes still in flight
      logic col_done;   // an output element is written this cycle
      logic out_free;   // the output register can take a value
   } status_type;

endpackage

FILE: sv/decayed_retention_attention.sv
// ----------------------------------------------------------------------------
// decayed_retention_attention
// Recurrent retention: per row, S = decay*S + k*v^T, then out = q^T*S.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | q, k, v element, last_in_sequence
//  rsp     | out       | rsp_valid/rsp_stall | out_elem, row_last
//  csr     | in        | csr_valid/csr_ready | decay_rate
//
//  A row takes DIM requests, one per cycle, then an update pass over the whole
//  matrix and an output pass column by column, both paced by the single read
//  port of the matrix RAM.
//  Reset clears the sequencer and marks the matrix as zero; no sweep is run.
//  req_stall is high from the last request of a row until its output row has
//  been issued. A stalled output holds the next column back.
// ----------------------------------------------------------------------------
module decayed_retention_attention import dra_pkg::*; #(
   parameter int DIM = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [ELEM_W-1:0]  req_q_elem,
   input  logic signed [ELEM_W-1:0]  req_k_elem,
   input  logic signed [ELEM_W-1:0]  req_v_elem,
   input  logic                      req_last_in_sequence,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [STATE_W-1:0] rsp_out_elem,
   output logic                      rsp_row_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [DECAY_W-1:0]        csr_data
);

   localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int SW = (DIM > 1) ? $clog2(DIM * DIM) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] elem_idx, row_a, col_b;
   logic [SW-1:0] mat_idx;

   assign csr_ready = 1'b1;

   dra_ctrl #(.DIM(DIM)) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_last_in_sequence (req_last_in_sequence),
      .status               (status),
      .cmd                  (cmd),
      .elem_idx             (elem_idx),
      .row_a                (row_a),
      .col_b                (col_b),
      .mat_idx              (mat_idx)
   );

   dra_datapath #(.DIM(DIM)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .elem_idx     (elem_idx),
      .row_a        (row_a),
      .col_b        (col_b),
      .mat_idx      (mat_idx),
      .req_q_elem   (req_q_elem),
      .req_k_elem   (req_k_elem),
      .req_v_elem   (req_v_elem),
      .csr_valid    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_elem (rsp_out_elem),
      .rsp_row_last (rsp_row_last)
   );

endmodule

FILE: sv/dra_ram.sv
// ----------------------------------------------------------------------------
// dra_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dra_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/dra_ctrl.sv
// ----------------------------------------------------------------------------
// dra_ctrl
// Sequencer: gathers a row, walks the matrix update, then walks the output
// columns one at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dra_ctrl import dra_pkg::*; #(
   parameter int DIM = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_last_in_sequence,
   input  status_type status,
   output cmd_type    cmd,
   output logic [(DIM > 1 ? $clog2(DIM) : 1)-1:0]         elem_idx,
   output logic [(DIM > 1 ? $clog2(DIM) : 1)-1:0]         row_a,
   output logic [(DIM > 1 ? $clog2(DIM) : 1)-1:0]         col_b,
   output logic [(DIM > 1 ? $clog2(DIM * DIM) : 1)-1:0]   mat_idx
);

   localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int SW = (DIM > 1) ? $clog2(DIM * DIM) : 1;
   localparam logic [IW-1:0] LAST = IW'(DIM - 1);
   localparam logic [SW-1:0] STEP = SW'(DIM);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_UPD       = 3'd1;
   localparam logic [2:0] S_UPD_DRAIN = 3'd2;
   localparam logic [2:0] S_OUT_HOLD  = 3'd3;
   localparam logic [2:0] S_OUT_RUN   = 3'd4;
   localparam logic [2:0] S_OUT_WAIT  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] elem_ff, elem_in;
   logic [IW-1:0] a_ff, a_in;
   logic [IW-1:0] b_ff, b_in;
   logic [SW-1:0] sidx_ff, sidx_in;
   logic          seq_end_ff, seq_end_in;
   logic          accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      elem_in    = elem_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      sidx_in    = sidx_ff;
      seq_end_in = seq_end_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.row_wr = 1'b1;
               if (elem_ff == LAST) begin
                  elem_in    = '0;
                  seq_end_in = req_last_in_sequence;
                  a_in       = '0;
                  b_in       = '0;
                  sidx_in    = '0;
                  state_in   = S_UPD;
               end else begin
                  elem_in = elem_ff + 1'b1;
               end
            end
         end
         S_UPD: begin
            cmd.upd_issue = 1'b1;
            sidx_in       = sidx_ff + 1'b1;
            if (b_ff == LAST) begin
               b_in = '0;
               if (a_ff == LAST) begin
                  state_in = S_UPD_DRAIN;
               end else begin
                  a_in = a_ff + 1'b1;
               end
            end else begin
               b_in = b_ff + 1'b1;
            end
         end
         S_UPD_DRAIN: begin
            if (!status.upd_busy) begin
               cmd.clr_zero = 1'b1;
               b_in         = '0;
               state_in     = S_OUT_HOLD;
            end
         end
         S_OUT_HOLD: begin
            if (status.out_free) begin
               a_in     = '0;
               sidx_in  = SW'(b_ff);
               state_in = S_OUT_RUN;
            end
         end
         S_OUT_RUN: begin
            cmd.out_issue = 1'b1;
            cmd.out_first = (a_ff == '0);
            cmd.out_last  = (a_ff == LAST);
            cmd.col_last  = (b_ff == LAST);
            sidx_in       = sidx_ff + STEP;
            if (a_ff == LAST) begin
               state_in = S_OUT_WAIT;
            end else begin
               a_in = a_ff + 1'b1;
            end
         end
         S_OUT_WAIT: begin
            if (status.col_done) begin
               if (b_ff == LAST) begin
                  cmd.set_zero = seq_end_ff;
                  state_in     = S_IDLE;
               end else begin
                  b_in     = b_ff + 1'b1;
                  state_in = S_OUT_HOLD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         elem_ff    <= '0;
         seq_end_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         elem_ff    <= elem_in;
         seq_end_ff <= seq_end_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      sidx_ff <= sidx_in;
   end

   assign elem_idx = elem_ff;
   assign row_a    = a_ff;
   assign col_b    = b_ff;
   assign mat_idx  = sidx_ff;

   `DRA_ASSERT(a_one_phase, !(cmd.upd_issue && cmd.out_issue),
      "update and output issued together")
   `DRA_ASSERT(a_out_after_update, (state_ff == S_OUT_RUN) |-> !status.upd_busy,
      "output read while matrix update still in flight")
   `DRA_ASSERT(a_done_in_wait, status.col_done |-> (state_ff == S_OUT_WAIT),
      "output element finished outside the wait state")
   `DRA_ASSERT(a_no_update_idle, (state_ff == S_IDLE) |=> !status.upd_busy,
      "update pipeline busy while gathering a row")

endmodule

FILE: sv/dra_datapath.sv
// ----------------------------------------------------------------------------
// dra_datapath
// Row buffers, matrix store, update and dot-product pipelines, decay
// register and output register.
// ----------------------------------------------------------------------------
module dra_datapath import dra_pkg::*; #(
   parameter int DIM = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic [(DIM > 1 ? $clog2(DIM) : 1)-1:0]       elem_idx,
   input  logic [(DIM > 1 ? $clog2(DIM) : 1)-1:0]       row_a,
   input  logic [(DIM > 1 ? $clog2(DIM) : 1)-1:0]       col_b,
   input  logic [(DIM > 1 ? $clog2(DIM * DIM) : 1)-1:0] mat_idx,
   input  logic signed [ELEM_W-1:0]    req_q_elem,
   input  logic signed [ELEM_W-1:0]    req_k_elem,
   input  logic signed [ELEM_W-1:0]    req_v_elem,
   input  logic                        csr_valid,
   input  logic [DECAY_W-1:0]          csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [STATE_W-1:0]   rsp_out_elem,
   output logic                        rsp_row_last
);

   localparam int SW    = (DIM > 1) ? $clog2(DIM * DIM) : 1;
   localparam int PW    = ELEM_W + STATE_W;              // q times S
   localparam int ACC_W = PW + $clog2(DIM) + 1;
   localparam int DPW   = STATE_W + DECAY_W + 1;         // S times decay
   localparam int SUM_W = STATE_W + 2;

   logic [DECAY_W-1:0] decay_ff;
   logic               zero_ff;

   logic signed [ELEM_W-1:0]  q_rd, k_rd, v_rd;
   logic signed [STATE_W-1:0] s_rd;
   logic [SW-1:0]             wr_idx_p1_ff, wr_idx_p2_ff, wr_idx_p3_ff;
   logic                      upd_p1_ff, upd_p2_ff, upd_p3_ff;
   logic signed [2*ELEM_W-1:0] kvp_ff;
   logic signed [DPW-1:0]      decp_ff;
   logic signed [STATE_W-1:0]  sum_ff;

   logic signed [DPW-1:0]     dec_r;
   logic signed [2*ELEM_W-1:0] kv_r;
   logic signed [SUM_W-1:0]   sum_full;
   logic signed [STATE_W-1:0] sum_sat;
   logic signed [STATE_W-1:0] s_op;

   logic               out_p1_ff, first_p1_ff, last_p1_ff, col_last_p1_ff;
   logic               out_p2_ff, first_p2_ff, last_p2_ff, col_last_p2_ff;
   logic               done_ff, done_col_last_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] acc_r;
   logic signed [STATE_W-1:0] acc_sat;

   logic                      rsp_valid_ff;
   logic signed [STATE_W-1:0] rsp_elem_ff;
   logic                      rsp_last_ff;

   dra_ram #(.WIDTH(ELEM_W), .DEPTH(DIM)) u_q_ram (
      .clock(clock), .wr_en(cmd.row_wr), .wr_addr(elem_idx), .wr_data(req_q_elem),
      .rd_addr(row_a), .rd_data(q_rd)
   );
   dra_ram #(.WIDTH(ELEM_W), .DEPTH(DIM)) u_k_ram (
      .clock(clock), .wr_en(cmd.row_wr), .wr_addr(elem_idx), .wr_data(req_k_elem),
      .rd_addr(row_a), .rd_data(k_rd)
   );
   dra_ram #(.WIDTH(ELEM_W), .DEPTH(DIM)) u_v_ram (
      .clock(clock), .wr_en(cmd.row_wr), .wr_addr(elem_idx), .wr_data(req_v_elem),
      .rd_addr(col_b), .rd_data(v_rd)
   );
   dra_ram #(.WIDTH(STATE_W), .DEPTH(DIM * DIM)) u_s_ram (
      .clock(clock), .wr_en(upd_p3_ff), .wr_addr(wr_idx_p3_ff), .wr_data(sum_ff),
      .rd_addr(mat_idx), .rd_data(s_rd)
   );

   // While the zero flag is set the whole matrix reads as zero; the next
   // update pass overwrites every entry, so no clearing sweep is needed.
   assign s_op = zero_ff ? '0 : s_rd;

   always_comb begin
      dec_r    = (decp_ff + DPW'(32768)) >>> 16;
      kv_r     = (kvp_ff + (2*ELEM_W)'(2048)) >>> 12;
      sum_full = SUM_W'(dec_r) + SUM_W'(kv_r);
      if (sum_full[SUM_W-1:STATE_W-1] != {(SUM_W-STATE_W+1){sum_full[SUM_W-1]}}) begin
         sum_sat = sum_full[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                     : {1'b0, {(STATE_W-1){1'b1}}};
      end else begin
         sum_sat = sum_full[STATE_W-1:0];
      end
   end

   always_comb begin
      acc_in = (first_p2_ff ? '0 : acc_ff) + ACC_W'(prod_ff);
      acc_r  = (acc_ff + ACC_W'(2048)) >>> 12;
      if (acc_r[ACC_W-1:STATE_W-1] != {(ACC_W-STATE_W+1){acc_r[ACC_W-1]}}) begin
         acc_sat = acc_r[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                  : {1'b0, {(STATE_W-1){1'b1}}};
      end else begin
         acc_sat = acc_r[STATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_RESET;
         zero_ff      <= 1'b1;
         upd_p1_ff    <= 1'b0;
         upd_p2_ff    <= 1'b0;
         upd_p3_ff    <= 1'b0;
         out_p1_ff    <= 1'b0;
         out_p2_ff    <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            decay_ff <= csr_data;
         end
         if (cmd.set_zero) begin
            zero_ff <= 1'b1;
         end else if (cmd.clr_zero) begin
            zero_ff <= 1'b0;
         end
         upd_p1_ff <= cmd.upd_issue;
         upd_p2_ff <= upd_p1_ff;
         upd_p3_ff <= upd_p2_ff;
         out_p1_ff <= cmd.out_issue;
         out_p2_ff <= out_p1_ff;
         done_ff   <= out_p2_ff && last_p2_ff;
         if (done_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      wr_idx_p1_ff     <= mat_idx;
      wr_idx_p2_ff     <= wr_idx_p1_ff;
      wr_idx_p3_ff     <= wr_idx_p2_ff;
      kvp_ff           <= k_rd * v_rd;
      decp_ff          <= s_op * $signed({1'b0, decay_ff});
      sum_ff           <= sum_sat;
      first_p1_ff      <= cmd.out_first;
      last_p1_ff       <= cmd.out_last;
      col_last_p1_ff   <= cmd.col_last;
      first_p2_ff      <= first_p1_ff;
      last_p2_ff       <= last_p1_ff;
      col_last_p2_ff   <= col_last_p1_ff;
      prod_ff          <= q_rd * s_rd;
      if (out_p2_ff) begin
         acc_ff <= acc_in;
      end
      done_col_last_ff <= col_last_p2_ff;
      if (done_ff) begin
         rsp_elem_ff <= acc_sat;
         rsp_last_ff <= done_col_last_ff;
      end
   end

   assign status.upd_busy = upd_p1_ff || upd_p2_ff || upd_p3_ff;
   assign status.col_done = done_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_elem = rsp_elem_ff;
   assign rsp_row_last = rsp_last_ff;

endmodule

FILE: tb/tb_decayed_retention_attention.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decayed_retention_attention
// Drives rows of query, key and value elements into the retention block,
// predicts each output row from a local copy of the decayed matrix and checks
// every output element in order, across several decay settings.
// ----------------------------------------------------------------------------
module tb_decayed_retention_attention import dra_pkg::*; ();

   localparam int DIM = 16;

   typedef struct {
      logic signed [ELEM_W-1:0] q;
      logic signed [ELEM_W-1:0] k;
      logic signed [ELEM_W-1:0] v;
      logic                     seq_end;
      logic                     chk;      // typed-in expectation present
      logic signed [STATE_W-1:0] exp_out;
   } dir_row_type;

   typedef struct {
      logic signed [STATE_W-1:0] out_elem;
      logic                      row_last;
   } out_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [ELEM_W-1:0] req_q_elem = '0;
   logic signed [ELEM_W-1:0] req_k_elem = '0;
   logic signed [ELEM_W-1:0] req_v_elem = '0;
   logic req_last_in_sequence = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [STATE_W-1:0] rsp_out_elem;
   logic rsp_row_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [DECAY_W-1:0] csr_data = '0;

   decayed_retention_attention #(.DIM(DIM)) uut (.*);

   // Local copy of the block's state.
   logic signed [STATE_W-1:0] kv_state [DIM][DIM];
   logic signed [ELEM_W-1:0]  q_buf [DIM];
   logic signed [ELEM_W-1:0]  k_buf [DIM];
   logic signed [ELEM_W-1:0]  v_buf [DIM];
   int unsigned               elem_pos;
   logic [DECAY_W-1:0]        decay_now;

   out_item_type expected_outputs [$];
   logic signed [STATE_W-1:0] typed_outputs [$];
   logic                      typed_check [$];
   int  errors = 0;
   bit  long_hold = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic signed [STATE_W-1:0] sat_to_state(logic signed [127:0] x);
      if (x > 128'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -128'sd2147483648) return 32'sh80000000;
      return x[STATE_W-1:0];
   endfunction

   // Floor shift of an exact sum after adding half an LSB.
   function automatic logic signed [127:0] round_down(logic signed [127:0] x, int s);
      logic signed [127:0] y;
      y = x + (128'sd1 <<< (s - 1));
      return y >>> s;
   endfunction

   // Absorbs one request; on the last element of a row, updates the matrix and
   // queues the output row it produces.
   task automatic retention_step(logic signed [ELEM_W-1:0] q, logic signed [ELEM_W-1:0] k,
                                 logic signed [ELEM_W-1:0] v, logic seq_end,
                                 logic chk, logic signed [STATE_W-1:0] typed);
      logic signed [127:0] kv_term, dec_term, acc;
      out_item_type item;
      q_buf[elem_pos] = q;
      k_buf[elem_pos] = k;
      v_buf[elem_pos] = v;
      if (elem_pos + 1 < DIM) begin
         elem_pos++;
         return;
      end
      elem_pos = 0;
      for (int a = 0; a < DIM; a++) begin
         for (int b = 0; b < DIM; b++) begin
            kv_term = 128'(k_buf[a]) * 128'(v_buf[b]);
            dec_term = 128'(kv_state[a][b]) * $signed({1'b0, decay_now});
            kv_state[a][b] = sat_to_state(round_down(dec_term, 16) + round_down(kv_term, 12));
         end
      end
      for (int b = 0; b < DIM; b++) begin
         acc = 0;
         for (int a = 0; a < DIM; a++) acc += 128'(q_buf[a]) * 128'(kv_state[a][b]);
         item.out_elem = sat_to_state(round_down(acc, 12));
         item.row_last = (b == DIM - 1);
         expected_outputs.push_back(item);
         typed_outputs.push_back(typed);
         typed_check.push_back(chk);
      end
      if (seq_end) begin
         foreach (kv_state[a, b]) kv_state[a][b] = '0;
      end
   endtask

   task automatic send_request(logic signed [ELEM_W-1:0] q, logic signed [ELEM_W-1:0] k,
                               logic signed [ELEM_W-1:0] v, logic seq_end,
                               logic chk, logic signed [STATE_W-1:0] typed);
      req_valid <= 1'b1;
      req_q_elem <= q;
      req_k_elem <= k;
      req_v_elem <= v;
      req_last_in_sequence <= seq_end;
      do @(posedge clock); while (req_stall);
      retention_step(q, k, v, seq_end, chk, typed);
   endtask

   task automatic idle_req(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_outputs();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DIM * (2 * DIM + 10)) @(posedge clock);
   endtask

   task automatic write_decay(logic [DECAY_W-1:0] val);
      csr_valid <= 1'b1;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      decay_now = val;
   endtask

   function automatic logic signed [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return $signed(16'($urandom_range(0, 15)));
         default: return $signed(16'($urandom));
      endcase
   endfunction

   // Output checker: compares every accepted element with the oldest expectation.
   always @(posedge clock) begin
      out_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected output elem=%0d last=%0b", $time, rsp_out_elem,
                     rsp_row_last);
            errors++;
         end else begin
            want = expected_outputs.pop_front();
            if (typed_check.pop_front() && typed_outputs[0] !== want.out_elem) begin
               $display("%0t: typed-in value %0d disagrees with prediction %0d", $time,
                        typed_outputs[0], want.out_elem);
               errors++;
            end
            void'(typed_outputs.pop_front());
            if (rsp_out_elem !== want.out_elem) begin
               $display("%0t: out_elem expected %0d actual %0d", $time, want.out_elem,
                        rsp_out_elem);
               errors++;
            end
            if (rsp_row_last !== want.row_last) begin
               $display("%0t: row_last expected %0b actual %0b", $time, want.row_last,
                        rsp_row_last);
               errors++;
            end
         end
      end
   end

   // Receiver stall pattern, with one long hold-off while requests keep coming.
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            for (hold = 0; hold < 3000; hold++) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= ($urandom_range(0, 99) < 40);
         end
      end
   end

   dir_row_type dir_rows [$];
   logic [DECAY_W-1:0] decay_list [5] = '{16'd0, 16'd65535, 16'd32768, 16'd61440, 16'd1};

   initial begin
      dir_row_type r;
      int rows;
      foreach (kv_state[a, b]) kv_state[a][b] = '0;
      elem_pos = 0;
      decay_now = DECAY_RESET;

      // Directed rows: zeros out of a fresh state, then extremes.
      for (int i = 0; i < DIM; i++) begin
         r.q = 0; r.k = 16'sh7FFF; r.v = 16'sh7FFF; r.seq_end = (i == 0);
         r.chk = (i == DIM - 1); r.exp_out = 0;
         dir_rows.push_back(r);
      end
      for (int i = 0; i < DIM; i++) begin
         r.q = 16'sh8000; r.k = 16'sh8000; r.v = (i == 0) ? 16'sh7FFF : 16'sh8000;
         r.seq_end = (i == DIM - 1); r.chk = 1'b0; r.exp_out = 0;
         dir_rows.push_back(r);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_request(dir_rows[i].q, dir_rows[i].k, dir_rows[i].v, dir_rows[i].seq_end,
                      dir_rows[i].chk, dir_rows[i].exp_out);

      // Saturation: maximum decay and repeated maximal rows without clearing.
      drain_outputs();
      write_decay(16'd65535);
      repeat (3 * DIM)
         send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, '0);

      foreach (decay_list[p]) begin
         drain_outputs();
         write_decay(decay_list[p]);
         rows = (p == 2) ? 8 : 5;
         for (int rw = 0; rw < rows; rw++) begin
            if (p == 1 && rw == 1) long_hold = 1'b1;
            for (int i = 0; i < DIM; i++) begin
               if ($urandom_range(0, 4) == 0) idle_req($urandom_range(1, 12));
               send_request(rand_elem(), rand_elem(), rand_elem(),
                            ($urandom_range(0, 3) == 0), 1'b0, '0);
            end
            if (p == 3 && rw == 2) drain_outputs();
         end
      end

      drain_outputs();
      if (errors == 0 && expected_outputs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/dra_pkg.sv
sv/dra_ram.sv
sv/dra_ctrl.sv
sv/dra_datapath.sv
sv/decayed_retention_attention.sv
tb/tb_decayed_retention_attention.sv
